// ----- rtl/core/mbrsm_pkg.sv -----
// Shared types, constants and helpers for the multi-buffer register slot manager.
package mbrsm_pkg;

    localparam int MAX_READERS = 8;
    localparam int SLOTS       = MAX_READERS + 2;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 32;

    localparam int MODE_W   = 2;
    localparam int RID_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    // Subtractions needed to wrap current+1 into the smallest slot count (3)
    localparam int WRAP_STEPS = SLOTS / 3;

    localparam logic [CFG_W-1:0] NUM_READERS_RESET = CFG_W'(MAX_READERS);

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE      = 2'd0,
        MODE_READ_START = 2'd1,
        MODE_READ_END   = 2'd2,
        MODE_UNUSED     = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_BAD_READER = 2'd2,
        ST_BAD_SLOT   = 2'd3
    } t_status;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // Reduce v modulo n, v below SLOTS + 1 and n at least 3
    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] v,
                                                    input logic [SLOT_W-1:0] n);
        logic [SLOT_W:0] r;
        r = v;
        for (int k = 0; k < WRAP_STEPS; k++) begin
            if (r >= {1'b0, n}) begin
                r = r - {1'b0, n};
            end
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/mbrsm_ctrl.sv -----
// Sequencing controller: accept an item, then execute and commit it.
module mbrsm_ctrl import mbrsm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: begin
                if (i_valid) begin
                    n_state = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        o_stall       = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            CS_EXEC: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

// ----- rtl/core/mbrsm_dp.sv -----
// Datapath: slot stores, read bookkeeping, free-slot search and result register.
module mbrsm_dp import mbrsm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [RID_W-1:0]       i_reader_id,
    input  logic [SLOT_W-1:0]      i_slot_index,
    input  logic [VALUE_WIDTH-1:0] i_data_in,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [SLOT_W-1:0]      o_slot_out,
    output logic [VALUE_WIDTH-1:0] o_data_out,
    output logic                   o_cached,
    output logic [STATUS_W-1:0]    o_status
);

    logic [CFG_W-1:0]       r_num_readers;
    logic [SLOT_W-1:0]      r_cur;
    logic [COUNT_WIDTH-1:0] r_read_cnt;
    logic [VALUE_WIDTH-1:0] r_values [SLOTS];
    // Outstanding reads per slot: started minus ended, modulo the count width
    logic [COUNT_WIDTH-1:0] r_diff [SLOTS];
    logic [SLOTS-1:0]       r_free;
    logic [MAX_READERS-1:0] r_seen;
    logic [SLOT_W-1:0]      r_last [MAX_READERS];

    t_mode                  r_mode;
    logic [RID_W-1:0]       r_rid;
    logic [SLOT_W-1:0]      r_sidx;
    logic [VALUE_WIDTH-1:0] r_data;

    logic                   r_out_valid;
    logic [SLOT_W-1:0]      r_out_slot;
    logic [VALUE_WIDTH-1:0] r_out_data;
    logic                   r_out_cached;
    t_status                r_out_status;

    logic [CFG_W-1:0]       nrd;
    logic [SLOT_W-1:0]      nslots;
    logic [SLOT_W-1:0]      start;
    logic [SLOTS-1:0]       cand;
    logic                   found_hi;
    logic                   found_lo;
    logic [SLOT_W-1:0]      sel_hi;
    logic [SLOT_W-1:0]      sel_lo;
    logic                   found;
    logic [SLOT_W-1:0]      sel;
    logic                   rid_ok;
    logic                   sidx_ok;
    logic                   hit_cached;
    logic [SLOT_W-1:0]      diff_addr;
    logic [COUNT_WIDTH-1:0] diff_rd;
    logic [COUNT_WIDTH-1:0] diff_new;
    logic                   do_write;
    logic                   do_rstart;
    logic                   do_rend;
    logic [SLOT_W-1:0]      res_slot;
    logic [VALUE_WIDTH-1:0] res_data;
    logic                   res_cached;
    t_status                res_status;

    // Effective reader count, clamped to 1..MAX_READERS
    always_comb begin
        if (r_num_readers == '0) begin
            nrd = CFG_W'(1);
        end else if (r_num_readers > CFG_W'(MAX_READERS)) begin
            nrd = CFG_W'(MAX_READERS);
        end else begin
            nrd = r_num_readers;
        end
        nslots = SLOT_W'(nrd) + SLOT_W'(2);
        start  = slot_wrap({1'b0, r_cur} + (SLOT_W+1)'(1), nslots);
    end

    // Free-slot search in cyclic order from start
    always_comb begin
        found_hi = 1'b0;
        found_lo = 1'b0;
        sel_hi   = '0;
        sel_lo   = '0;
        for (int j = 0; j < SLOTS; j++) begin
            cand[j] = r_free[j] && (SLOT_W'(j) < nslots) && (SLOT_W'(j) != r_cur);
        end
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                found_lo = 1'b1;
                sel_lo   = SLOT_W'(j);
                if (SLOT_W'(j) >= start) begin
                    found_hi = 1'b1;
                    sel_hi   = SLOT_W'(j);
                end
            end
        end
        found = found_hi || found_lo;
        sel   = found_hi ? sel_hi : sel_lo;
    end

    always_comb begin
        rid_ok     = {1'b0, r_rid} < nrd;
        sidx_ok    = r_sidx < nslots;
        hit_cached = r_seen[r_rid] && (r_last[r_rid] == r_cur);
        diff_addr  = (r_mode == MODE_WRITE) ? r_cur : r_sidx;
        diff_rd    = (diff_addr < SLOT_W'(SLOTS)) ? r_diff[diff_addr] : '0;
        // Retired slot adds the running read count; a read end retires one read
        diff_new   = (r_mode == MODE_WRITE) ? diff_rd + r_read_cnt
                                            : diff_rd - COUNT_WIDTH'(1);
    end

    always_comb begin
        res_slot   = '0;
        res_data   = '0;
        res_cached = 1'b0;
        res_status = ST_OK;
        unique case (r_mode)
            MODE_WRITE: begin
                res_slot   = found ? sel : r_cur;
                res_status = found ? ST_OK : ST_NO_FREE;
            end
            MODE_READ_START: begin
                if (!rid_ok) begin
                    res_status = ST_BAD_READER;
                end else begin
                    res_slot   = r_cur;
                    res_data   = r_values[r_cur];
                    res_cached = hit_cached;
                end
            end
            MODE_READ_END: begin
                if (!rid_ok) begin
                    res_status = ST_BAD_READER;
                end else if (!sidx_ok) begin
                    res_status = ST_BAD_SLOT;
                end else begin
                    res_slot = r_sidx;
                end
            end
            MODE_UNUSED: res_status = ST_OK;
            default:     res_status = ST_OK;
        endcase
    end

    assign do_write  = i_cmd.commit && (r_mode == MODE_WRITE) && found;
    assign do_rstart = i_cmd.commit && (r_mode == MODE_READ_START) && rid_ok && !hit_cached;
    assign do_rend   = i_cmd.commit && (r_mode == MODE_READ_END) && rid_ok && sidx_ok;

    assign o_stat.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_readers <= NUM_READERS_RESET;
            r_cur         <= '0;
            r_read_cnt    <= '0;
            r_free        <= '1;
            r_seen        <= '0;
            r_out_valid   <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_values[s] <= '0;
                r_diff[s]   <= '0;
            end
            for (int r = 0; r < MAX_READERS; r++) begin
                r_last[r] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_num_readers <= i_cfg_wr_data;
            end
            if (do_write) begin
                r_values[sel]  <= r_data;
                r_diff[r_cur]  <= diff_new;
                r_free[r_cur]  <= (diff_new == '0);
                r_read_cnt     <= '0;
                r_seen         <= '0;
                r_cur          <= sel;
            end
            if (do_rstart) begin
                r_read_cnt     <= r_read_cnt + COUNT_WIDTH'(1);
                r_seen[r_rid]  <= 1'b1;
                r_last[r_rid]  <= r_cur;
            end
            if (do_rend) begin
                r_diff[r_sidx] <= diff_new;
                r_free[r_sidx] <= (diff_new == '0);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= t_mode'(i_mode);
            r_rid  <= i_reader_id;
            r_sidx <= i_slot_index;
            r_data <= i_data_in;
        end
        if (i_cmd.commit) begin
            r_out_slot   <= res_slot;
            r_out_data   <= res_data;
            r_out_cached <= res_cached;
            r_out_status <= res_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_slot_out = r_out_slot;
    assign o_data_out = r_out_data;
    assign o_cached   = r_out_cached;
    assign o_status   = r_out_status;

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed item not presented");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur < SLOT_W'(SLOTS))
        else $error("current slot out of range");

    a_write_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> (r_cur != $past(r_cur)) && (r_read_cnt == '0))
        else $error("write did not move to a new slot");

endmodule

// ----- rtl/core/multi_buffer_register_slot_manager.sv -----
// Flow: an item is accepted while the controller is idle; its result is registered
// when it commits from the execute state, once the result register is free.
// The input stalls until the item commits, so no new item is taken before then;
// a write finds a free slot by a combinational priority search over active slots.
// Reset (i_rst_n low, synchronous) clears every slot, count and reader mark,
// makes slot 0 current and sets the reader count to eight.
module multi_buffer_register_slot_manager import mbrsm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: reader count
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    // input item channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [RID_W-1:0]       i_reader_id,
    input  logic [SLOT_W-1:0]      i_slot_index,
    input  logic [VALUE_WIDTH-1:0] i_data_in,
    // result item channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SLOT_W-1:0]      o_slot_out,
    output logic [VALUE_WIDTH-1:0] o_data_out,
    output logic                   o_cached,
    output logic [STATUS_W-1:0]    o_status
);

    // Controller/datapath handshake: capture the item, commit its effect
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Hold the input stalled while an item executes; advance once the
    // result register can take the outcome (empty, or being drained).
    mbrsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Slot values, outstanding-read counts with per-slot free flags,
    // per-reader marks, and the result register that parts the two sides.
    mbrsm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_mode        (i_mode),
        .i_reader_id   (i_reader_id),
        .i_slot_index  (i_slot_index),
        .i_data_in     (i_data_in),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_slot_out    (o_slot_out),
        .o_data_out    (o_data_out),
        .o_cached      (o_cached),
        .o_status      (o_status)
    );

endmodule
